// File: src/rrc_pkg.sv
// ----------------------------------------------------------------------------
// rrc_pkg
// shared types, codes and constants of the rectangle raster canvas
// ----------------------------------------------------------------------------
package rrc_pkg;

    localparam int MAX_SIDE_DEF = 256;
    localparam int CFG_W        = 9;
    localparam int CHAR_W       = 8;
    localparam int Q_W          = 24;
    localparam int FRAC_W       = 8;
    localparam int GEO_W        = 27;
    localparam int CMP_W        = 11;
    localparam int EDGE_SPAN    = 256;

    localparam logic [CHAR_W-1:0] BG_RESET = 8'd32;

    localparam logic [1:0] OP_CLEAR = 2'd0;
    localparam logic [1:0] OP_DRAW  = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    localparam logic [1:0] STAT_OK       = 2'd0;
    localparam logic [1:0] STAT_BAD_SIZE = 2'd1;
    localparam logic [1:0] STAT_OUTSIDE  = 2'd2;

    localparam logic [1:0] CFG_CANVAS_WIDTH    = 2'd0;
    localparam logic [1:0] CFG_CANVAS_HEIGHT   = 2'd1;
    localparam logic [1:0] CFG_BACKGROUND_CHAR = 2'd2;

    typedef struct packed {
        logic [1:0]              operation;
        logic                    filled;
        logic signed [Q_W-1:0]   rect_left;
        logic signed [Q_W-1:0]   rect_top;
        logic signed [Q_W-1:0]   rect_width;
        logic signed [Q_W-1:0]   rect_height;
        logic [CHAR_W-1:0]       paint_char;
        logic [7:0]              read_col;
        logic [7:0]              read_row;
    } in_item_t;

    typedef struct packed {
        logic [1:0]        status;
        logic [CHAR_W-1:0] cell_char;
    } out_item_t;

    typedef struct packed {
        logic start;
        logic is_draw;
        logic filled;
    } sweep_cmd_t;

    typedef struct packed {
        logic wr_en;
        logic done;
    } sweep_ctl_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SWEEP,
        ST_READ,
        ST_DONE
    } state_t;

    typedef enum logic [1:0] {
        SW_IDLE,
        SW_PREP,
        SW_RUN
    } sweep_state_t;

endpackage

// File: src/rectangle_raster_canvas_top.sv
// ----------------------------------------------------------------------------
// rectangle_raster_canvas_top
// character canvas with clear, rectangle draw and cell read commands
// ----------------------------------------------------------------------------
// usage:
//   in_valid/in_stall/in_data carry one command per transfer: clear, draw or
//   read. out_valid/out_stall/out_data return exactly one result per command.
//   cfg_we/cfg_index/cfg_data write canvas width, height and background
//   character; write them only while no command is in flight.
//   a clear or draw with a canvas in use of w by h cells sweeps all w*h cells
//   before the result, the memory write port taking one cell per cycle.
//   a read goes through the registered memory read; a bad rectangle size, an
//   out of range read or an empty canvas goes straight to the result.
//   one command is in work at a time; a new command is taken as soon as the
//   previous result sits in the output register, even while it is stalled.
//   when the receiver stalls, the result stays in the output register and a
//   finished command waits until that register frees.
//   reset clears control and the configuration registers (background 32, sides 0); the
//   canvas memory is not cleared, so issue a clear before the first read.
// ----------------------------------------------------------------------------
module rectangle_raster_canvas_top #(
    parameter int MAX_SIDE = rrc_pkg::MAX_SIDE_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  rrc_pkg::in_item_t          in_data,
    output logic                       out_valid,
    input  logic                       out_stall,
    output rrc_pkg::out_item_t         out_data,
    input  logic                       cfg_we,
    input  logic [1:0]                 cfg_index,
    input  logic [rrc_pkg::CFG_W-1:0]  cfg_data
);
    import rrc_pkg::*;

    localparam int CW = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
    localparam int SW = CW + 1;
    localparam int AW = 2 * CW;

    state_t state_reg, state_next;

    logic [CFG_W-1:0]  canvas_width_reg;
    logic [CFG_W-1:0]  canvas_height_reg;
    logic [CHAR_W-1:0] background_char_reg;

    logic [1:0]        status_reg, status_next;
    logic [CHAR_W-1:0] char_reg, char_next;

    logic      out_valid_reg;
    out_item_t out_data_reg;

    logic [SW-1:0] side_w, side_h;
    logic          accept, out_free, load_out, side_zero, rd_outside, bad_size;

    sweep_cmd_t        sweep_cmd;
    sweep_ctl_t        sweep_ctl;
    logic [CW-1:0]     wr_col, wr_row;
    logic [CHAR_W-1:0] wr_data;
    logic              rd_en;
    logic [CHAR_W-1:0] rd_data;

    // sides in use, clamped to the memory size
    assign side_w = (CMP_W'(canvas_width_reg) > CMP_W'(MAX_SIDE)) ?
                    SW'(MAX_SIDE) : SW'(canvas_width_reg);
    assign side_h = (CMP_W'(canvas_height_reg) > CMP_W'(MAX_SIDE)) ?
                    SW'(MAX_SIDE) : SW'(canvas_height_reg);

    assign side_zero  = (side_w == '0) || (side_h == '0);
    assign rd_outside = (CMP_W'(in_data.read_col) >= CMP_W'(side_w)) ||
                        (CMP_W'(in_data.read_row) >= CMP_W'(side_h));
    assign bad_size   = ($signed(in_data.rect_width) <= 0) ||
                        ($signed(in_data.rect_height) <= 0);

    assign in_stall = state_reg != ST_IDLE;
    assign accept   = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            canvas_width_reg    <= '0;
            canvas_height_reg   <= '0;
            background_char_reg <= BG_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_CANVAS_WIDTH:    canvas_width_reg    <= cfg_data;
                CFG_CANVAS_HEIGHT:   canvas_height_reg   <= cfg_data;
                CFG_BACKGROUND_CHAR: background_char_reg <= cfg_data[CHAR_W-1:0];
                default:             ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        char_reg   <= char_next;
        if (load_out)
        begin
            out_data_reg.status    <= status_reg;
            out_data_reg.cell_char <= char_reg;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        status_next = status_reg;
        char_next   = char_reg;
        sweep_cmd   = '0;
        rd_en       = 1'b0;
        load_out    = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    status_next = STAT_OK;
                    char_next   = '0;
                    state_next  = ST_DONE;
                    case (in_data.operation)
                        OP_CLEAR:
                        begin
                            if (!side_zero)
                            begin
                                sweep_cmd.start = 1'b1;
                                state_next      = ST_SWEEP;
                            end
                        end
                        OP_DRAW:
                        begin
                            if (bad_size)
                            begin
                                status_next = STAT_BAD_SIZE;
                            end
                            else if (!side_zero)
                            begin
                                sweep_cmd.start   = 1'b1;
                                sweep_cmd.is_draw = 1'b1;
                                sweep_cmd.filled  = in_data.filled;
                                state_next        = ST_SWEEP;
                            end
                        end
                        OP_READ:
                        begin
                            if (rd_outside)
                            begin
                                status_next = STAT_OUTSIDE;
                            end
                            else
                            begin
                                rd_en      = 1'b1;
                                state_next = ST_READ;
                            end
                        end
                        default:
                        begin
                            status_next = STAT_OK;
                        end
                    endcase
                end
            end
            ST_SWEEP:
            begin
                if (sweep_ctl.done)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_READ:
            begin
                char_next  = rd_data;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    rrc_sweep #(
        .CW (CW)
    ) u_sweep (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (sweep_cmd),
        .rect_left   (in_data.rect_left),
        .rect_top    (in_data.rect_top),
        .rect_width  (in_data.rect_width),
        .rect_height (in_data.rect_height),
        .paint_char  (in_data.paint_char),
        .bg_char     (background_char_reg),
        .side_w      (side_w),
        .side_h      (side_h),
        .ctl         (sweep_ctl),
        .wr_col      (wr_col),
        .wr_row      (wr_row),
        .wr_data     (wr_data)
    );

    rrc_mem #(
        .AW (AW)
    ) u_mem (
        .clk   (clk),
        .we    (sweep_ctl.wr_en),
        .waddr ({wr_row, wr_col}),
        .wdata (wr_data),
        .re    (rd_en),
        .raddr ({CW'(in_data.read_row), CW'(in_data.read_col)}),
        .rdata (rd_data)
    );

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

`ifndef NO_ASSERTIONS
    a_done_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        sweep_ctl.done |-> state_reg == ST_SWEEP)
        else $error("sweep done outside sweep state");

    a_write_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        sweep_ctl.wr_en |-> state_reg == ST_SWEEP)
        else $error("canvas write outside sweep state");

    a_write_in_canvas: assert property (@(posedge clk) disable iff (!rst_n)
        sweep_ctl.wr_en |-> ({1'b0, wr_col} < side_w) && ({1'b0, wr_row} < side_h))
        else $error("canvas write outside canvas in use");

    a_read_then_done: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_READ |=> state_reg == ST_DONE)
        else $error("read result not taken after one cycle");

    a_load_frees: assert property (@(posedge clk) disable iff (!rst_n)
        load_out |-> out_free && state_reg == ST_DONE)
        else $error("result loaded over a pending result");
`endif

endmodule

// File: src/rrc_mem.sv
// ----------------------------------------------------------------------------
// rrc_mem
// canvas cell memory, one write and one registered read port
// ----------------------------------------------------------------------------
module rrc_mem #(
    parameter int AW = 16
) (
    input  logic                      clk,
    input  logic                      we,
    input  logic [AW-1:0]             waddr,
    input  logic [rrc_pkg::CHAR_W-1:0] wdata,
    input  logic                      re,
    input  logic [AW-1:0]             raddr,
    output logic [rrc_pkg::CHAR_W-1:0] rdata
);
    import rrc_pkg::*;

    logic [CHAR_W-1:0] mem [2**AW];
    logic [CHAR_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: src/rrc_sweep.sv
// ----------------------------------------------------------------------------
// rrc_sweep
// walks the canvas in use one cell per cycle and decides which cells to write
// ----------------------------------------------------------------------------
module rrc_sweep #(
    parameter int CW = 8
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  rrc_pkg::sweep_cmd_t             cmd,
    input  logic signed [rrc_pkg::Q_W-1:0]  rect_left,
    input  logic signed [rrc_pkg::Q_W-1:0]  rect_top,
    input  logic signed [rrc_pkg::Q_W-1:0]  rect_width,
    input  logic signed [rrc_pkg::Q_W-1:0]  rect_height,
    input  logic [rrc_pkg::CHAR_W-1:0]      paint_char,
    input  logic [rrc_pkg::CHAR_W-1:0]      bg_char,
    input  logic [CW:0]                     side_w,
    input  logic [CW:0]                     side_h,
    output rrc_pkg::sweep_ctl_t             ctl,
    output logic [CW-1:0]                   wr_col,
    output logic [CW-1:0]                   wr_row,
    output logic [rrc_pkg::CHAR_W-1:0]      wr_data
);
    import rrc_pkg::*;

    localparam int SW = CW + 1;
    localparam logic signed [GEO_W-1:0] SPAN    = GEO_W'(EDGE_SPAN);
    localparam logic signed [GEO_W-1:0] SPAN_M1 = GEO_W'(EDGE_SPAN - 1);

    sweep_state_t state_reg, state_next;
    logic [CW-1:0] col_reg, col_next;
    logic [CW-1:0] row_reg, row_next;

    logic              draw_reg;
    logic              filled_reg;
    logic [CHAR_W-1:0] char_reg;
    logic signed [GEO_W-1:0] left_reg, top_reg, right_reg, bottom_reg;
    logic signed [GEO_W-1:0] rightm_reg, leftp_reg, bottomm_reg, topp_reg;

    logic signed [GEO_W-1:0] x_pos, y_pos;
    logic in_x, in_y, edge_hit, hit, last_col, last_row;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= SW_IDLE;
            col_reg   <= '0;
            row_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            col_reg   <= col_next;
            row_reg   <= row_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            draw_reg   <= cmd.is_draw;
            filled_reg <= cmd.filled;
            char_reg   <= cmd.is_draw ? paint_char : bg_char;
            left_reg   <= GEO_W'(rect_left);
            top_reg    <= GEO_W'(rect_top);
            right_reg  <= GEO_W'(rect_left) + GEO_W'(rect_width);
            bottom_reg <= GEO_W'(rect_top) + GEO_W'(rect_height);
        end
        if (state_reg == SW_PREP)
        begin
            rightm_reg  <= right_reg - SPAN_M1;
            leftp_reg   <= left_reg + SPAN;
            bottomm_reg <= bottom_reg - SPAN_M1;
            topp_reg    <= top_reg + SPAN;
        end
    end

    // cell position in q18.8
    assign x_pos = $signed(GEO_W'({col_reg, {FRAC_W{1'b0}}}));
    assign y_pos = $signed(GEO_W'({row_reg, {FRAC_W{1'b0}}}));

    assign in_x     = (x_pos >= left_reg) && (x_pos <= right_reg);
    assign in_y     = (y_pos >= top_reg) && (y_pos <= bottom_reg);
    assign edge_hit = (x_pos >= rightm_reg) || (x_pos < leftp_reg) ||
                      (y_pos >= bottomm_reg) || (y_pos < topp_reg);
    assign hit      = !draw_reg || (in_x && in_y && (filled_reg || edge_hit));
    assign last_col = {1'b0, col_reg} == (side_w - SW'(1));
    assign last_row = {1'b0, row_reg} == (side_h - SW'(1));

    always_comb
    begin
        state_next = state_reg;
        col_next   = col_reg;
        row_next   = row_reg;
        ctl        = '0;
        case (state_reg)
            SW_IDLE:
            begin
                if (cmd.start)
                begin
                    state_next = SW_PREP;
                    col_next   = '0;
                    row_next   = '0;
                end
            end
            SW_PREP:
            begin
                state_next = SW_RUN;
            end
            SW_RUN:
            begin
                ctl.wr_en = hit;
                if (last_col)
                begin
                    col_next = '0;
                    if (last_row)
                    begin
                        ctl.done   = 1'b1;
                        state_next = SW_IDLE;
                    end
                    else
                    begin
                        row_next = row_reg + CW'(1);
                    end
                end
                else
                begin
                    col_next = col_reg + CW'(1);
                end
            end
            default:
            begin
                state_next = SW_IDLE;
            end
        endcase
    end

    assign wr_col  = col_reg;
    assign wr_row  = row_reg;
    assign wr_data = char_reg;

endmodule
